// ===== rtl/quad_region_point_and_overlap_test_macros.svh =====
// Assertion macros used by the top RTL module.
`ifndef QUAD_REGION_POINT_AND_OVERLAP_TEST_MACROS_SVH
`define QUAD_REGION_POINT_AND_OVERLAP_TEST_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled in reset.
`define QRPO_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen at a clock edge.
`define QRPO_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define QRPO_ASSERT(lbl, clk, rst_n, prop, msg)
`define QRPO_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/qrpo_pkg.sv =====
package qrpo_pkg;

  localparam int unsigned CoordWidthDef   = 32;
  localparam int unsigned FractionBitsDef = 16;

  // register index port width (eight corner registers)
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumCfg  = 8;

  // query modes
  localparam logic [1:0] MODE_POINT   = 2'd0;
  localparam logic [1:0] MODE_SEGMENT = 2'd1;
  localparam logic [1:0] MODE_REGION  = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  // points per lane group: region, query, far points of query, far points of region
  localparam int unsigned NumPts   = 16;
  localparam int unsigned NumCross = 48;

endpackage

// ===== rtl/qrpo_orient.sv =====
// Orientation lane: sign of (b-a)x(c-a) with a dead band, three register stages.
module qrpo_orient #(
  parameter int unsigned COORD_WIDTH   = qrpo_pkg::CoordWidthDef,
  parameter int unsigned FRACTION_BITS = qrpo_pkg::FractionBitsDef
) (
  input  logic                          clk_i,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  output logic                          pos_o,
  output logic                          neg_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;
  localparam longint unsigned EpsVal = (64'd1 << (2 * FRACTION_BITS)) / 64'd100000;
  localparam logic signed [PW:0] Eps = (PW+1)'(EpsVal);

  logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [PW:0]   cross_d;

  // stage 1: coordinate differences
  always_ff @(posedge clk_i) begin
    d1x_q <= DW'(bx_i) - DW'(ax_i);
    d1y_q <= DW'(cy_i) - DW'(ay_i);
    d2x_q <= DW'(cx_i) - DW'(ax_i);
    d2y_q <= DW'(by_i) - DW'(ay_i);
  end

  // stage 2: exact products
  always_ff @(posedge clk_i) begin
    p1_q <= d1x_q * d1y_q;
    p2_q <= d2x_q * d2y_q;
  end

  // stage 3: cross product against the dead band
  assign cross_d = (PW+1)'(p1_q) - (PW+1)'(p2_q);

  always_ff @(posedge clk_i) begin
    pos_o <= cross_d > Eps;
    neg_o <= cross_d < -Eps;
  end

endmodule

// ===== rtl/qrpo_dist.sv =====
// Close-corner lane: squared distance below the limit, three register stages.
module qrpo_dist #(
  parameter int unsigned COORD_WIDTH   = qrpo_pkg::CoordWidthDef,
  parameter int unsigned FRACTION_BITS = qrpo_pkg::FractionBitsDef
) (
  input  logic                          clk_i,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  output logic                          close_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;
  localparam longint unsigned LimVal =
    ((64'd1 << (2 * FRACTION_BITS)) + 64'd9999999999) / 64'd10000000000;
  localparam logic signed [PW:0] Lim = (PW+1)'(LimVal);

  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [PW-1:0] sx_q, sy_q;
  logic signed [PW:0]   sum_d;

  // stage 1: differences
  always_ff @(posedge clk_i) begin
    dx_q <= DW'(bx_i) - DW'(ax_i);
    dy_q <= DW'(by_i) - DW'(ay_i);
  end

  // stage 2: squares
  always_ff @(posedge clk_i) begin
    sx_q <= dx_q * dx_q;
    sy_q <= dy_q * dy_q;
  end

  // stage 3: sum and compare
  assign sum_d = (PW+1)'(sx_q) + (PW+1)'(sy_q);

  always_ff @(posedge clk_i) begin
    close_o <= sum_d < Lim;
  end

endmodule

// ===== rtl/quad_region_point_and_overlap_test.sv =====
// Channel   | Ports                                       | Transfer
// ----------+---------------------------------------------+----------------------------
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i            | edge with cfg_we_i high
// query     | start, busy, mode_i, pt0_x_i .. pt3_y_i     | edge with start && !busy
// result    | done_o, hit_o, region_degenerate_o,         | edge ending the done_o cycle
//           | query_degenerate_o                          |
//
// One query enters every cycle; busy is always low. Results appear in order, one
// cycle wide, after the difference, product and sign stages of the lanes and the
// combine stage. All 200 orientations and eight distances run in parallel lanes.
// Reset clears the corner registers and the valid pipeline. The receiver cannot
// stall, so the pipeline never holds.
module quad_region_point_and_overlap_test #(
  parameter int unsigned COORD_WIDTH   = qrpo_pkg::CoordWidthDef,
  parameter int unsigned FRACTION_BITS = qrpo_pkg::FractionBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qrpo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode_i,
  input  logic signed [COORD_WIDTH-1:0] pt0_x_i,
  input  logic signed [COORD_WIDTH-1:0] pt0_y_i,
  input  logic signed [COORD_WIDTH-1:0] pt1_x_i,
  input  logic signed [COORD_WIDTH-1:0] pt1_y_i,
  input  logic signed [COORD_WIDTH-1:0] pt2_x_i,
  input  logic signed [COORD_WIDTH-1:0] pt2_y_i,
  input  logic signed [COORD_WIDTH-1:0] pt3_x_i,
  input  logic signed [COORD_WIDTH-1:0] pt3_y_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          region_degenerate_o,
  output logic                          query_degenerate_o
);

  `include "quad_region_point_and_overlap_test_macros.svh"

  localparam int unsigned NP = qrpo_pkg::NumPts;
  localparam int unsigned NC = qrpo_pkg::NumCross;
  localparam logic signed [COORD_WIDTH-1:0] FarX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  logic [COORD_WIDTH-1:0] corner_q [qrpo_pkg::NumCfg];
  logic signed [COORD_WIDTH-1:0] px [NP];
  logic signed [COORD_WIDTH-1:0] py [NP];
  logic [2:0]       vld_q;
  logic [1:0]       mode_q [3];
  logic [4*NC-1:0]  opos, oneg;
  logic [7:0]       dpos, dneg, close;
  logic [NC-1:0]    xing;
  logic [3:0]       in_r, in_q;
  logic             hit_d, rdeg_d, qdeg_d;
  logic             xfer;

  assign busy = 1'b0;
  assign xfer = start && !busy;

  // corner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qrpo_pkg::NumCfg; i++) corner_q[i] <= '0;
    end else if (cfg_we_i) begin
      corner_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // point set: region, query, far points of query corners, far points of region corners
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px[k]    = corner_q[2*k];
      py[k]    = corner_q[2*k+1];
      px[8+k]  = FarX;
      px[12+k] = FarX;
      py[12+k] = corner_q[2*k+1];
    end
    px[4] = pt0_x_i; py[4] = pt0_y_i;
    px[5] = pt1_x_i; py[5] = pt1_y_i;
    px[6] = pt2_x_i; py[6] = pt2_y_i;
    px[7] = pt3_x_i; py[7] = pt3_y_i;
    for (int k = 0; k < 4; k++) py[8+k] = py[4+k];
  end

  // crossing lanes: four orientations per segment pair
  for (genvar s = 0; s < NC; s++) begin : g_cross
    localparam int G  = s / 16;
    localparam int K  = (s % 16) / 4;
    localparam int I  = s % 4;
    localparam int J  = (I + 1) % 4;
    localparam int P0 = (G == 1) ? 4 + I : I;
    localparam int P1 = (G == 1) ? 4 + J : J;
    localparam int A  = (G == 0) ? 4 + K : (G == 1) ? K : 4 + K;
    localparam int B  = (G == 0) ? 8 + K : (G == 1) ? 12 + K : 4 + ((K + 1) % 4);
    localparam int Ux [4] = '{P0, P0, A, A};
    localparam int Uy [4] = '{P1, P1, B, B};
    localparam int Uc [4] = '{A, B, P0, P1};
    for (genvar o = 0; o < 4; o++) begin : g_or
      qrpo_orient #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_or (
        .clk_i (clk_i),
        .ax_i  (px[Ux[o]]), .ay_i (py[Ux[o]]),
        .bx_i  (px[Uy[o]]), .by_i (py[Uy[o]]),
        .cx_i  (px[Uc[o]]), .cy_i (py[Uc[o]]),
        .pos_o (opos[4*s+o]),
        .neg_o (oneg[4*s+o])
      );
    end
  end

  // degeneracy lanes: adjacent-edge orientation and corner distance per quad
  for (genvar d = 0; d < 8; d++) begin : g_deg
    localparam int Base = (d / 4) * 4;
    localparam int Di   = Base + (d % 4);
    localparam int Dj   = Base + ((d + 1) % 4);
    localparam int Dk   = Base + ((d + 2) % 4);
    qrpo_orient #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_or (
      .clk_i (clk_i),
      .ax_i  (px[Di]), .ay_i (py[Di]),
      .bx_i  (px[Dj]), .by_i (py[Dj]),
      .cx_i  (px[Dk]), .cy_i (py[Dk]),
      .pos_o (dpos[d]),
      .neg_o (dneg[d])
    );
    qrpo_dist #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_dist (
      .clk_i   (clk_i),
      .ax_i    (px[Di]), .ay_i (py[Di]),
      .bx_i    (px[Dj]), .by_i (py[Dj]),
      .close_o (close[d])
    );
  end

  // valid and mode travel with the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_o <= 1'b0;
    end else begin
      vld_q  <= {vld_q[1:0], xfer};
      done_o <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q[0] <= mode_i;
    mode_q[1] <= mode_q[0];
    mode_q[2] <= mode_q[1];
  end

  // combine: strict opposite sides on both segments, ray parity, degeneracy and the hit per mode
  always_comb begin
    for (int s = 0; s < NC; s++) begin
      xing[s] = ((opos[4*s] & oneg[4*s+1]) | (oneg[4*s] & opos[4*s+1])) &
                ((opos[4*s+2] & oneg[4*s+3]) | (oneg[4*s+2] & opos[4*s+3]));
    end
    for (int k = 0; k < 4; k++) begin
      in_r[k] = ^xing[4*k +: 4];
      in_q[k] = ^xing[16 + 4*k +: 4];
    end
    rdeg_d = (|close[3:0]) | (|(~dpos[3:0] & ~dneg[3:0]));
    qdeg_d = 1'b0;
    case (mode_q[2])
      qrpo_pkg::MODE_POINT:   hit_d = in_r[0];
      qrpo_pkg::MODE_SEGMENT: hit_d = |xing[35:32];
      qrpo_pkg::MODE_REGION: begin
        hit_d  = (|in_r) | (|in_q) | (|xing[47:32]);
        qdeg_d = (|close[7:4]) | (|(~dpos[7:4] & ~dneg[7:4]));
      end
      default:                hit_d = 1'b0;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    hit_o               <= hit_d;
    region_degenerate_o <= rdeg_d;
    query_degenerate_o  <= qdeg_d;
  end

  `QRPO_ASSERT(a_latency, clk_i, rst_ni, xfer |-> ##4 done_o, "result missing four cycles after transfer")
  `QRPO_ASSERT(a_no_spurious, clk_i, rst_ni, done_o |-> $past(xfer, 4), "result without a transfer")
  `QRPO_ASSERT(a_qdeg_mode, clk_i, rst_ni, (done_o && query_degenerate_o) |-> ($past(mode_i, 4) == qrpo_pkg::MODE_REGION), "query degenerate outside region mode")
  `QRPO_ASSERT(a_unused_mode, clk_i, rst_ni, (done_o && ($past(mode_i, 4) == qrpo_pkg::MODE_UNUSED)) |-> !hit_o, "hit in unused mode")

endmodule

// ===== test/quad_region_point_and_overlap_test_checker.sv =====
`timescale 1ns / 1ps

// Watches the config, query and result channels, predicts each result and
// compares it with what the block returns.
module quad_region_point_and_overlap_test_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] pt_i [8],
  input  logic        done_o,
  input  logic        hit_o,
  input  logic        region_degenerate_o,
  input  logic        query_degenerate_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);

  typedef logic signed [127:0] wide_t;
  typedef wide_t quad_t [4];

  typedef struct packed {
    logic hit;
    logic region_deg;
    logic query_deg;
  } verdict_t;

  // dead band of the orientation test in Q32 (0.00001), far end of the ray
  localparam longint unsigned SideBand  = (64'd1 << 32) / 64'd100000;
  localparam longint          RayEndX   = 64'h7fff_ffff;
  localparam longint          MinDistSq = 1;
  localparam int unsigned     FifoDepth = 16;

  logic signed [31:0] corner_q [8];
  // prediction FIFO, far deeper than the four results in flight
  verdict_t           verdict_q [FifoDepth];
  logic [3:0]         wr_ptr_q, rd_ptr_q;

  // sign of the cross product (b - a) x (c - a), zero inside the dead band
  function automatic int side_of(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                 wide_t cx, wide_t cy);
    wide_t c;
    c = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    if (c > wide_t'(SideBand)) return 1;
    if (c < -wide_t'(SideBand)) return -1;
    return 0;
  endfunction

  // proper crossing: each segment's ends strictly on both sides of the other
  function automatic bit seg_cross(wide_t p0x, wide_t p0y, wide_t p1x, wide_t p1y,
                                   wide_t q0x, wide_t q0y, wide_t q1x, wide_t q1y);
    return (side_of(p0x, p0y, p1x, p1y, q0x, q0y) *
            side_of(p0x, p0y, p1x, p1y, q1x, q1y) < 0) &&
           (side_of(q0x, q0y, q1x, q1y, p0x, p0y) *
            side_of(q0x, q0y, q1x, q1y, p1x, p1y) < 0);
  endfunction

  function automatic bit edge_crossed(quad_t qx, quad_t qy,
                                      wide_t ax, wide_t ay, wide_t bx, wide_t by);
    for (int i = 0; i < 4; i++)
      if (seg_cross(qx[i], qy[i], qx[(i+1)%4], qy[(i+1)%4], ax, ay, bx, by))
        return 1'b1;
    return 1'b0;
  endfunction

  // ray cast toward far X, odd crossing count means inside
  function automatic bit point_inside(quad_t qx, quad_t qy, wide_t px, wide_t py);
    int n;
    n = 0;
    for (int i = 0; i < 4; i++)
      if (seg_cross(qx[i], qy[i], qx[(i+1)%4], qy[(i+1)%4], px, py,
                    wide_t'(RayEndX), py))
        n++;
    return n[0];
  endfunction

  function automatic bit quad_degenerate(quad_t qx, quad_t qy);
    wide_t dx, dy;
    for (int i = 0; i < 4; i++) begin
      dx = qx[(i+1)%4] - qx[i];
      dy = qy[(i+1)%4] - qy[i];
      if (dx * dx + dy * dy < wide_t'(MinDistSq)) return 1'b1;
    end
    for (int i = 0; i < 4; i++)
      if (side_of(qx[i], qy[i], qx[(i+1)%4], qy[(i+1)%4],
                  qx[(i+2)%4], qy[(i+2)%4]) == 0)
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic verdict_t predict_query(logic [1:0] mode);
    quad_t    rx, ry, qx, qy;
    verdict_t v;
    logic signed [31:0] c;
    for (int i = 0; i < 4; i++) begin
      rx[i] = corner_q[2*i];
      ry[i] = corner_q[2*i+1];
      c = pt_i[2*i];   qx[i] = c;
      c = pt_i[2*i+1]; qy[i] = c;
    end
    v = '0;
    case (mode)
      qrpo_pkg::MODE_POINT:   v.hit = point_inside(rx, ry, qx[0], qy[0]);
      qrpo_pkg::MODE_SEGMENT: v.hit = edge_crossed(rx, ry, qx[0], qy[0], qx[1], qy[1]);
      qrpo_pkg::MODE_REGION: begin
        v.query_deg = quad_degenerate(qx, qy);
        for (int i = 0; i < 4; i++)
          if (!v.hit) v.hit = point_inside(rx, ry, qx[i], qy[i]);
        for (int i = 0; i < 4; i++)
          if (!v.hit) v.hit = point_inside(qx, qy, rx[i], ry[i]);
        for (int i = 0; i < 4; i++)
          if (!v.hit)
            v.hit = edge_crossed(rx, ry, qx[i], qy[i], qx[(i+1)%4], qy[(i+1)%4]);
      end
      default: v.hit = 1'b0;
    endcase
    v.region_deg = quad_degenerate(rx, ry);
    return v;
  endfunction

  assign pending_o = int'(wr_ptr_q - rd_ptr_q);

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) corner_q[i] <= '0;
      wr_ptr_q       <= '0;
      rd_ptr_q       <= '0;
      fail_count_o   <= 0;
      result_count_o <= 0;
    end else begin
      // result transfer
      if (done_o) begin
        result_count_o <= result_count_o + 1;
        if (wr_ptr_q == rd_ptr_q) begin
          $display("%0t: unexpected result hit=%b rdeg=%b qdeg=%b", $time,
                   hit_o, region_degenerate_o, query_degenerate_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = verdict_q[rd_ptr_q];
          rd_ptr_q <= rd_ptr_q + 4'd1;
          if (want.hit !== hit_o || want.region_deg !== region_degenerate_o ||
              want.query_deg !== query_degenerate_o) begin
            $display("%0t: mismatch expected hit=%b rdeg=%b qdeg=%b, actual hit=%b rdeg=%b qdeg=%b",
                     $time, want.hit, want.region_deg, want.query_deg,
                     hit_o, region_degenerate_o, query_degenerate_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // query transfer, predicted against the current corners
      if (start && !busy) begin
        verdict_q[wr_ptr_q] <= predict_query(mode_i);
        wr_ptr_q            <= wr_ptr_q + 4'd1;
      end
      if (cfg_we_i) corner_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

endmodule

// ===== test/quad_region_point_and_overlap_test_tb.sv =====
`timescale 1ns / 1ps

module quad_region_point_and_overlap_test_tb;

  localparam int         CycleLimit  = 300000;
  localparam int         Scale       = 100 << 16;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        start;
  logic        busy;
  logic [1:0]  mode_i;
  logic [31:0] pt [8];
  logic        done_o, hit_o, region_degenerate_o, query_degenerate_o;
  int          fail_count, pending, result_count;
  int          cycle_count;
  int          idle_pct;
  int          mode_sent [4];
  logic signed [31:0] region [8];

  quad_region_point_and_overlap_test uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start, .busy, .mode_i,
    .pt0_x_i(pt[0]), .pt0_y_i(pt[1]), .pt1_x_i(pt[2]), .pt1_y_i(pt[3]),
    .pt2_x_i(pt[4]), .pt2_y_i(pt[5]), .pt3_x_i(pt[6]), .pt3_y_i(pt[7]),
    .done_o, .hit_o, .region_degenerate_o, .query_degenerate_o
  );

  quad_region_point_and_overlap_test_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start, .busy, .mode_i,
    .pt_i(pt), .done_o, .hit_o, .region_degenerate_o, .query_degenerate_o,
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one query transfer; start stays high unless the sender idles afterwards
  task automatic send_query(logic [1:0] mode, logic [31:0] p [8]);
    logic b;
    mode_i <= mode;
    for (int i = 0; i < 8; i++) pt[i] <= p[i];
    start <= 1'b1;
    do begin
      @(negedge clk_i);
      b = busy;
      @(posedge clk_i);
    end while (b);
    mode_sent[mode]++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // drains the pipeline, then rewrites all eight corners
  task automatic load_region(logic signed [31:0] c [8]);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 3'(i);
      cfg_wdata_i <= c[i];
      region[i]    = c[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // coordinate: mostly near the region, sometimes a corner, extreme or raw
  function automatic logic [31:0] pick_coord(int axis);
    int sel;
    sel = $urandom_range(15);
    if (sel == 0) return $urandom;
    if (sel == 1) return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    if (sel < 4) return region[2 * $urandom_range(3) + axis];
    return $signed(region[axis]) / 2 + $signed(region[4 + axis]) / 2 +
           int'($urandom_range(0, 3 * Scale)) - 3 * Scale / 2 +
           (($urandom_range(3) == 0) ? int'($urandom_range(0, 3)) : 0);
  endfunction

  task automatic random_queries(int n);
    logic [31:0] p [8];
    logic [1:0]  m;
    for (int k = 0; k < n; k++) begin
      m = ($urandom_range(19) == 0) ? qrpo_pkg::MODE_UNUSED : 2'($urandom_range(2));
      for (int i = 0; i < 8; i++) p[i] = pick_coord(i % 2);
      // at times repeat a corner or line up three corners to hit degenerate queries
      if ($urandom_range(7) == 0) begin
        p[2] = p[0];
        p[3] = p[1];
      end
      if ($urandom_range(7) == 0) begin
        p[4] = p[0] + 2 * (p[2] - p[0]);
        p[5] = p[1] + 2 * (p[3] - p[1]);
      end
      send_query(m, p);
    end
  endtask

  logic signed [31:0] box [8], huge [8], tilted [8], flat [8], dup [8];
  logic [31:0] q [8];

  initial begin
    int s;
    s = Scale;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    start       <= 1'b0;
    mode_i      <= qrpo_pkg::MODE_POINT;
    for (int i = 0; i < 8; i++) pt[i] <= '0;
    for (int i = 0; i < 8; i++) region[i] = '0;
    cycle_count <= 0;
    idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    box    = '{-s, -s, s, -s, s, s, -s, s};
    huge   = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
    tilted = '{-s, 0, 0, -2 * s, 3 * s / 2, s / 3, -s / 5, s};
    flat   = '{0, 0, s, 0, 2 * s, 0, s, s};
    dup    = '{0, 0, 0, 0, s, s, -s, s};

    // reset corners: all equal, region flagged degenerate
    q = '{0, 0, 0, 0, 0, 0, 0, 0};
    send_query(qrpo_pkg::MODE_POINT, q);
    send_query(qrpo_pkg::MODE_REGION, q);

    // directed checks on the square
    load_region(box);
    q = '{0, 0, 0, 0, 0, 0, 0, 0};
    send_query(qrpo_pkg::MODE_POINT, q);                         // center
    q = '{2 * s, 0, 0, 0, 0, 0, 0, 0};
    send_query(qrpo_pkg::MODE_POINT, q);                         // right of box
    q = '{32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0};
    send_query(qrpo_pkg::MODE_POINT, q);                         // zero-length ray
    q = '{32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0};
    send_query(qrpo_pkg::MODE_POINT, q);
    q = '{0, s, 0, 0, 0, 0, 0, 0};
    send_query(qrpo_pkg::MODE_POINT, q);                         // on top edge
    q = '{-s, 0, 0, 0, 0, 0, 0, 0};
    send_query(qrpo_pkg::MODE_POINT, q);                         // on left edge
    q = '{0, 0, 2 * s, 0, 0, 0, 0, 0};
    send_query(qrpo_pkg::MODE_SEGMENT, q);                       // crosses right edge
    q = '{-s, s, s, s, 0, 0, 0, 0};
    send_query(qrpo_pkg::MODE_SEGMENT, q);                       // colinear with edge
    q = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0};
    send_query(qrpo_pkg::MODE_SEGMENT, q);
    q = '{-s / 2, -s / 2, s / 2, -s / 2, s / 2, s / 2, -s / 2, s / 2};
    send_query(qrpo_pkg::MODE_REGION, q);                        // query inside
    q = '{-2 * s, -2 * s, 2 * s, -2 * s, 2 * s, 2 * s, -2 * s, 2 * s};
    send_query(qrpo_pkg::MODE_REGION, q);                        // region inside query
    q = '{-2 * s, -s / 2, 2 * s, -s / 2, 2 * s, s / 2, -2 * s, s / 2};
    send_query(qrpo_pkg::MODE_REGION, q);                        // cross shape, edges only
    q = '{3 * s, 3 * s, 4 * s, 3 * s, 4 * s, 4 * s, 3 * s, 4 * s};
    send_query(qrpo_pkg::MODE_REGION, q);                        // disjoint
    q = '{s, s, s, s, 2 * s, 2 * s, 0, 2 * s};
    send_query(qrpo_pkg::MODE_REGION, q);                        // repeated corner
    q = '{0, 0, s, 0, 2 * s, 0, s, s};
    send_query(qrpo_pkg::MODE_REGION, q);                        // colinear query
    q = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_query(qrpo_pkg::MODE_REGION, q);
    q = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    send_query(qrpo_pkg::MODE_UNUSED, q);

    // random phases over several region settings and idle rates
    for (int ph = 0; ph < 20; ph++) begin
      case (ph % 5)
        0: load_region(box);
        1: load_region(huge);
        2: load_region(tilted);
        3: load_region(flat);
        default: load_region(dup);
      endcase
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 51;
        2: idle_pct = 0;
        default: idle_pct = 38;
      endcase
      random_queries(64);
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d point, %0d segment, %0d overlap, %0d unused-mode queries;",
             mode_sent[0], mode_sent[1], mode_sent[2], mode_sent[3]);
    $display("%0d results checked over five region shapes and four idle phases.",
             result_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/qrpo_pkg.sv
rtl/qrpo_orient.sv
rtl/qrpo_dist.sv
rtl/quad_region_point_and_overlap_test.sv
test/quad_region_point_and_overlap_test_checker.sv
test/quad_region_point_and_overlap_test_tb.sv
